/* rtl/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// Clocked on a rising edge; the reset form disables the check while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only out of reset.
`define RPI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked on every edge, reset included.
`define RPI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* rtl/rpi_pkg.sv */
// Shared types and constants for the radial profile interpolator.
// No dependencies; the top level, divider, front and back import this package.
package rpi_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 2);
  localparam int CFG_W       = 13;
  localparam int RAD_W       = 31;
  localparam int Q_W         = 32;
  localparam int OPND_W      = 33;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int DQ_W        = 35;
  localparam int QUO_W       = DQ_W + 2;
  localparam int DIV_CNT_W   = $clog2(DQ_W);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [11:0]           entry_index;
    logic [RAD_W-1:0]      entry_radius;
    logic signed [Q_W-1:0] entry_density;
    logic signed [Q_W-1:0] entry_energy;
    logic signed [Q_W-1:0] entry_pressure;
    logic signed [Q_W-1:0] entry_velocity;
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] pos_z;
    logic                  last_particle;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] density_out;
    logic signed [Q_W-1:0] energy_out;
    logic signed [Q_W-1:0] pressure_out;
    logic signed [Q_W-1:0] vel_x;
    logic signed [Q_W-1:0] vel_y;
    logic signed [Q_W-1:0] vel_z;
    logic                  last_result;
  } out_t;

  // One table row: val[0] density, [1] energy, [2] pressure, [3] velocity.
  typedef struct packed {
    logic [RAD_W-1:0]          radius;
    logic [3:0][Q_W-1:0]       val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/radial_profile_interpolator_unit.sv */
// Radial profile interpolator, top level. Depends on rpi_pkg, rpi_front, rpi_back.
// Load request: written to the table at the edge it leaves the queue, once the engine is idle.
// Query request: one query at a time; its work is the 32-bit square root, the search (up to
//   13 probes) and seven serial 35-bit quotients, some skipped on zero intervals or zero
//   radius and cut short on quotient overflow.
// Results strobe out_valid for one cycle and cannot be held off; reset (synchronous, rst_n
//   low): queue emptied, engine idle, entry_count back to 2.
module radial_profile_interpolator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // request side
  input  logic                      start,
  output logic                      busy,
  input  rpi_pkg::in_t              in_data,
  // result side
  output logic                      out_valid,
  output rpi_pkg::out_t             out_data,
  // entry_count register
  input  logic                      cfg_we,
  input  logic [rpi_pkg::CFG_W-1:0] cfg_wdata
);
  import rpi_pkg::*;

  logic [CFG_W-1:0] entry_count_r;
  logic             req_valid, req_query, req_pop;
  in_t              req_item;

  // Config register; the user must write it only while no request is in flight; not enforced here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CFG_W'(2);
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // Front: two-deep request queue; busy means the queue is full.
  rpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req_query (req_query),
    .req_item  (req_item),
    .req_pop   (req_pop)
  );

  // Back: table RAM, radius, search and interpolation engine.
  rpi_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_query   (req_query),
    .req_item    (req_item),
    .req_pop     (req_pop),
    .entry_count (entry_count_r),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

/* rtl/rpi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rpi_div.sv */
// Serial signed divider, one quotient bit per cycle, quotient clamped at 2^35.
// Depends on rpi_pkg.
module rpi_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [rpi_pkg::PROD_W-1:0]   num,
  input  logic signed [rpi_pkg::OPND_W-1:0]   den,
  output logic                                done,
  output logic signed [rpi_pkg::QUO_W-1:0]    quo
);
  import rpi_pkg::*;

  logic [PROD_W-1:0]      num_mag;
  logic [OPND_W-2:0]      den_mag;
  logic [PROD_W-DQ_W-1:0] num_hi;
  logic                   ovf;
  logic [OPND_W-2:0]      rem_r, den_r;
  logic [DQ_W-1:0]        sh_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   run_r, neg_r, ovf_r, done_r;
  logic [OPND_W-1:0]      trial;
  logic                   ge;
  logic [DQ_W:0]          mag;

  assign num_mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
  assign den_mag = den[OPND_W-1] ? (OPND_W-1)'(-den) : den[OPND_W-2:0];
  assign num_hi  = num_mag[PROD_W-1:DQ_W];
  assign ovf     = {1'b0, num_hi} >= den_mag;

  assign trial = {rem_r, sh_r[DQ_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= (OPND_W-1)'(num_hi);
        sh_r  <= num_mag[DQ_W-1:0];
        den_r <= den_mag;
        neg_r <= num[PROD_W-1] ^ den[OPND_W-1];
        ovf_r <= ovf;
        cnt_r <= DIV_CNT_W'(DQ_W - 1);
        run_r <= !ovf;
        done_r <= ovf;
      end else if (run_r) begin
        rem_r <= ge ? (OPND_W-1)'(trial - {1'b0, den_r}) : trial[OPND_W-2:0];
        sh_r  <= {sh_r[DQ_W-2:0], ge};
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign mag  = ovf_r ? {1'b1, {DQ_W{1'b0}}} : {1'b0, sh_r};
  assign quo  = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done = done_r;

endmodule

/* rtl/rpi_front.sv */
// Front end: takes requests, classifies them and queues them two deep.
// Depends on rpi_pkg.
module rpi_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  rpi_pkg::in_t in_data,
  output logic         req_valid,
  output logic         req_query,
  output rpi_pkg::in_t req_item,
  input  logic         req_pop
);
  import rpi_pkg::*;

  in_t        slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign busy = (count_r == 2'd2);
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (req_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, req_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

  assign req_valid = (count_r != 2'd0);
  assign req_item  = slot_r[rd_ptr_r];
  assign req_query = (req_item.operation == OP_QUERY);

endmodule

/* rtl/rpi_back.sv */
// Back end: table writes, radius, binary search, interpolation and projection.
// Depends on rpi_pkg, rpi_ram and rpi_div.
module rpi_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  logic                       req_query,
  input  rpi_pkg::in_t               req_item,
  output logic                       req_pop,
  input  logic [rpi_pkg::CFG_W-1:0]  entry_count,
  output logic                       out_valid,
  output rpi_pkg::out_t              out_data
);
  import rpi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_RD_FIRST, S_RD_LAST,
    S_CLAMP, S_SEARCH, S_CMP, S_FIX, S_RD_LO, S_RD_HI, S_GOT_HI,
    S_MUL, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  state_t                 state_r;
  logic signed [Q_W-1:0]  pos_r [3];
  logic                   last_r;
  logic [CNT_W-1:0]       n_r, jl_r, ju_r, jm_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [63:0]            acc_r, sqv_r;
  logic [33:0]            rem_r;
  logic [31:0]            root_r;
  logic [4:0]             step_r;
  logic [RAD_W-1:0]       rad_r, r0_r, rlast_r, rlo_r, rhi_r;
  logic                   asc_r;
  logic [ADDR_W-1:0]      idx_r;
  logic [3:0][Q_W-1:0]    lo_r, hi_r;
  logic signed [Q_W-1:0]  res_r [7];
  logic [2:0]             k_r;
  logic                   out_valid_r;
  out_t                   out_r;

  entry_t                 rd, wr;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic [CNT_W-1:0]       n_cfg, jm_c, jl_f, idx_w;
  logic signed [OPND_W-1:0] mul_a, mul_b, den;
  logic signed [Q_W-1:0]  addend, pos_sel, sat_res;
  logic signed [Q_W+5:0]  sum;
  logic                   den_zero;
  logic [35:0]            rem_t, sq_trial;
  logic                   sq_ge;
  logic [31:0]            root_nxt;
  logic [33:0]            rem_nxt;
  logic [RAD_W-1:0]       rad_a, rad_b;
  logic                   div_start, div_done;
  logic signed [QUO_W-1:0] div_quo;

  // Table RAM: one row per entry, all five quantities side by side.
  assign wr.radius = req_item.entry_radius;
  assign wr.val[0] = req_item.entry_density;
  assign wr.val[1] = req_item.entry_energy;
  assign wr.val[2] = req_item.entry_pressure;
  assign wr.val[3] = req_item.entry_velocity;
  assign ram_we = (state_r == S_IDLE) && req_valid && !req_query &&
                  (int'(req_item.entry_index) < TABLE_DEPTH);
  assign req_pop = (state_r == S_IDLE) && req_valid;

  rpi_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(req_item.entry_index)),
    .wdata (wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
  assign rd = entry_t'(ram_rdata);

  rpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (int'(entry_count) < 2) begin
      n_cfg = CNT_W'(2);
    end else if (int'(entry_count) > TABLE_DEPTH) begin
      n_cfg = CNT_W'(TABLE_DEPTH);
    end else begin
      n_cfg = CNT_W'(entry_count);
    end
  end

  assign jm_c = CNT_W'(({1'b0, ju_r} + {1'b0, jl_r}) >> 1);

  always_comb begin
    case (state_r)
      S_RD_LAST: ram_raddr = ADDR_W'(n_r - CNT_W'(1));
      S_SEARCH:  ram_raddr = ADDR_W'(jm_c - CNT_W'(1));
      S_RD_LO:   ram_raddr = idx_r;
      S_RD_HI:   ram_raddr = idx_r + ADDR_W'(1);
      default:   ram_raddr = '0;
    endcase
  end

  // Square root, one result bit per step.
  assign rem_t    = {rem_r, sqv_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = rem_t >= sq_trial;
  assign root_nxt = {root_r[30:0], sq_ge};
  assign rem_nxt  = sq_ge ? 34'(rem_t - sq_trial) : rem_t[33:0];

  // Clamp: raise to first radius, then lower to last.
  assign rad_a = (rad_r < r0_r) ? r0_r : rad_r;
  assign rad_b = (rad_a > rd.radius) ? rd.radius : rad_a;

  always_comb begin
    if (rad_r == r0_r) begin
      jl_f = CNT_W'(1);
    end else if (rad_r == rlast_r) begin
      jl_f = n_r - CNT_W'(1);
    end else begin
      jl_f = jl_r;
    end
    idx_w = (jl_f == '0) ? '0 : jl_f - CNT_W'(1);
    if (idx_w > n_r - CNT_W'(2)) begin
      idx_w = n_r - CNT_W'(2);
    end
  end

  // Steps 0..3 interpolate the four quantities, 4..6 project the velocity.
  always_comb begin
    case (k_r[1:0])
      2'd0:    pos_sel = pos_r[0];
      2'd1:    pos_sel = pos_r[1];
      default: pos_sel = pos_r[2];
    endcase
    case (state_r)
      S_SQ0: begin
        mul_a = OPND_W'(pos_r[0]);
        mul_b = OPND_W'(pos_r[0]);
      end
      S_SQ1: begin
        mul_a = OPND_W'(pos_r[1]);
        mul_b = OPND_W'(pos_r[1]);
      end
      S_SQ2: begin
        mul_a = OPND_W'(pos_r[2]);
        mul_b = OPND_W'(pos_r[2]);
      end
      default: begin
        if (!k_r[2]) begin
          mul_a = $signed({2'b00, rad_r} - {2'b00, rlo_r});
          mul_b = $signed({hi_r[k_r[1:0]][Q_W-1], hi_r[k_r[1:0]]} -
                          {lo_r[k_r[1:0]][Q_W-1], lo_r[k_r[1:0]]});
        end else begin
          mul_a = OPND_W'(res_r[3]);
          mul_b = OPND_W'(pos_sel);
        end
      end
    endcase
  end

  assign den      = k_r[2] ? $signed({2'b00, rad_r})
                           : $signed({2'b00, rhi_r} - {2'b00, rlo_r});
  assign den_zero = (den == '0);
  assign addend   = k_r[2] ? '0 : $signed(lo_r[k_r[1:0]]);
  assign div_start = (state_r == S_DIV_GO) && !den_zero;

  assign sum = (Q_W+6)'(addend) + (Q_W+6)'(div_quo);
  always_comb begin
    if (sum[Q_W+5:Q_W-1] == '0 || sum[Q_W+5:Q_W-1] == '1) begin
      sat_res = sum[Q_W-1:0];
    end else if (sum[Q_W+5]) begin
      sat_res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      prod_r      <= mul_a * mul_b;
      unique case (state_r)
        S_IDLE: begin
          if (req_valid && req_query) begin
            pos_r[0] <= req_item.pos_x;
            pos_r[1] <= req_item.pos_y;
            pos_r[2] <= req_item.pos_z;
            last_r   <= req_item.last_particle;
            n_r      <= n_cfg;
            state_r  <= S_SQ0;
          end
        end
        S_SQ0: state_r <= S_SQ1;
        S_SQ1: begin
          acc_r   <= prod_r[63:0];
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          acc_r   <= acc_r + prod_r[63:0];
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          sqv_r   <= acc_r + prod_r[63:0];
          rem_r   <= '0;
          root_r  <= '0;
          step_r  <= 5'd31;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          sqv_r  <= {sqv_r[61:0], 2'b00};
          if (step_r == '0) begin
            rad_r   <= root_nxt[31] ? '1 : root_nxt[RAD_W-1:0];
            state_r <= S_RD_FIRST;
          end else begin
            step_r <= step_r - 5'd1;
          end
        end
        S_RD_FIRST: state_r <= S_RD_LAST;
        S_RD_LAST: begin
          r0_r    <= rd.radius;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          rlast_r <= rd.radius;
          rad_r   <= rad_b;
          asc_r   <= (rd.radius >= r0_r);
          jl_r    <= '0;
          ju_r    <= n_r + CNT_W'(1);
          state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          if (ju_r - jl_r > CNT_W'(1)) begin
            jm_r    <= jm_c;
            state_r <= S_CMP;
          end else begin
            state_r <= S_FIX;
          end
        end
        S_CMP: begin
          if ((rad_r >= rd.radius) == asc_r) begin
            jl_r <= jm_r;
          end else begin
            ju_r <= jm_r;
          end
          state_r <= S_SEARCH;
        end
        S_FIX: begin
          idx_r   <= ADDR_W'(idx_w);
          state_r <= S_RD_LO;
        end
        S_RD_LO: state_r <= S_RD_HI;
        S_RD_HI: begin
          rlo_r   <= rd.radius;
          lo_r    <= rd.val;
          state_r <= S_GOT_HI;
        end
        S_GOT_HI: begin
          rhi_r   <= rd.radius;
          hi_r    <= rd.val;
          k_r     <= '0;
          state_r <= S_MUL;
        end
        S_MUL: state_r <= S_DIV_GO;
        S_DIV_GO: begin
          if (den_zero) begin
            res_r[k_r] <= addend;
            k_r        <= k_r + 3'd1;
            state_r    <= (k_r == 3'd6) ? S_OUT : S_MUL;
          end else begin
            state_r <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_r[k_r] <= sat_res;
            k_r        <= k_r + 3'd1;
            state_r    <= (k_r == 3'd6) ? S_OUT : S_MUL;
          end
        end
        S_OUT: begin
          out_valid_r        <= 1'b1;
          out_r.density_out  <= res_r[0];
          out_r.energy_out   <= res_r[1];
          out_r.pressure_out <= res_r[2];
          out_r.vel_x        <= res_r[4];
          out_r.vel_y        <= res_r[5];
          out_r.vel_z        <= res_r[6];
          out_r.last_result  <= last_r;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/rpi_checker.sv */
// Port-level checks for the radial profile interpolator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rpi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A result never repeats on the next cycle: each query passes the root, search and divide states.
  `RPI_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid)
  // Reset leaves no result pending.
  `RPI_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)
  // The queue only fills through an accepted request.
  `RPI_ASSERT(a_busy_rise, clk, rst_n, $rose(busy) |-> $past(start))

endmodule

bind radial_profile_interpolator_unit rpi_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
